// ===== sv/fwsi_pkg.sv =====
package fwsi_pkg;

	localparam int Depth   = 16;
	localparam int DataW   = 32;
	localparam int CountW  = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [DataW-1:0] in_value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [DataW-1:0] out_value;
		logic [CountW-1:0]       count;
		logic                    is_empty;
	} result_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                    ins;
		logic                    sorted;
		logic                    rem;
		logic signed [DataW-1:0] value;
	} cell_cmd_t;

endpackage

// ===== sv/fifo_with_sorted_insert_core.sv =====
// result and done are registered: done rises in the cycle after the one with start
// throughput: one request per cycle, busy stays low; the whole cell chain
//   shifts and compares in parallel
// reset: arst_n clears the count, the cell valid bits and done; cell data is not reset
// the receiver cannot stall: done marks each result for a single cycle, and result holds until the next request
module fifo_with_sorted_insert_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fwsi_pkg::req_t      req,
	output logic                done,
	output fwsi_pkg::result_t   result
);

	localparam int N = fwsi_pkg::Depth;

	fwsi_pkg::cell_cmd_t                cmd;
	logic signed [fwsi_pkg::DataW-1:0]  cell_val [N];
	logic                               cell_vld [N];
	logic                               found    [N+1];

	logic [fwsi_pkg::CountW-1:0] entry_count_q;
	logic [fwsi_pkg::CountW-1:0] count_next;
	fwsi_pkg::result_t           res_d;
	fwsi_pkg::result_t           result_q;
	logic                        done_q;
	logic                        accept;
	logic                        is_add;
	logic                        is_rem;
	logic                        full;
	logic                        empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = cell_vld[N-1];
	assign empty  = !cell_vld[0];
	assign is_add = (req.op == fwsi_pkg::OP_APPEND) || (req.op == fwsi_pkg::OP_INSERT);
	assign is_rem = (req.op == fwsi_pkg::OP_REMOVE);

	always_comb begin
		cmd.ins    = accept && is_add && !full;
		cmd.sorted = (req.op == fwsi_pkg::OP_INSERT);
		cmd.rem    = accept && is_rem && !empty;
		cmd.value  = req.in_value;
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [fwsi_pkg::DataW-1:0] lv;
		logic                              lvld;
		logic signed [fwsi_pkg::DataW-1:0] rv;
		logic                              rvld;

		if (i == 0) begin : g_head
			assign lv   = '0;
			assign lvld = 1'b1;
		end else begin : g_mid_l
			assign lv   = cell_val[i-1];
			assign lvld = cell_vld[i-1];
		end

		if (i == N-1) begin : g_tail
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rv   = cell_val[i+1];
			assign rvld = cell_vld[i+1];
		end

		fwsi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_val  (lv),
			.left_vld  (lvld),
			.right_val (rv),
			.right_vld (rvld),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.val       (cell_val[i]),
			.vld       (cell_vld[i])
		);
	end

	always_comb begin
		count_next = entry_count_q;
		if (cmd.ins) begin
			count_next = entry_count_q + fwsi_pkg::CountW'(1);
		end else if (cmd.rem) begin
			count_next = entry_count_q - fwsi_pkg::CountW'(1);
		end

		res_d.status    = fwsi_pkg::ST_DONE;
		res_d.out_value = '0;
		if (is_add && full) begin
			res_d.status = fwsi_pkg::ST_FULL;
		end else if (is_rem && empty) begin
			res_d.status = fwsi_pkg::ST_EMPTY;
		end else if (is_rem) begin
			res_d.out_value = cell_val[0];
		end
		res_d.count    = count_next;
		res_d.is_empty = (count_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			entry_count_q <= count_next;
			done_q        <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/fwsi_cell.sv =====
module fwsi_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fwsi_pkg::cell_cmd_t              cmd,
	input  logic signed [fwsi_pkg::DataW-1:0] left_val,
	input  logic                             left_vld,
	input  logic signed [fwsi_pkg::DataW-1:0] right_val,
	input  logic                             right_vld,
	input  logic                             found_in,
	output logic                             found_out,
	output logic signed [fwsi_pkg::DataW-1:0] val,
	output logic                             vld
);

	logic signed [fwsi_pkg::DataW-1:0] val_q;
	logic                              vld_q;
	logic                              take;

	// first free cell, or, on a sorted insert, first stored entry not below the new value
	assign take      = !vld_q || (cmd.sorted && (val_q >= cmd.value));
	assign found_out = found_in || take;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (found_in) begin
				val_q <= left_val;
			end else if (take) begin
				val_q <= cmd.value;
			end
		end else if (cmd.rem) begin
			val_q <= right_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.ins) begin
			vld_q <= vld_q || left_vld;
		end else if (cmd.rem) begin
			vld_q <= right_vld;
		end
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule
